// ===== hw/rtl/beq_pkg.sv =====
// Shared types, constants and codes for the batch export queue.
package beq_pkg;

  // Queue geometry
  localparam int STORE_DEPTH  = 32;
  localparam int HANDLE_WIDTH = 16;
  localparam int PTR_W        = $clog2(STORE_DEPTH);
  localparam int CNT_W        = $clog2(STORE_DEPTH + 1);
  localparam int TIME_W       = 64;
  localparam int TOTAL_W      = 32;
  localparam int DELAY_W      = 32;
  localparam int SIZE_W       = 6;
  localparam int LIMIT_W      = 6;

  // Configuration port
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;

  typedef enum logic [1:0] {
    CMD_ENQUEUE = 2'd0,
    CMD_DEQUEUE = 2'd1,
    CMD_FLUSH   = 2'd2,
    CMD_CHECK   = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    ST_OK          = 2'd0,
    ST_NOT_READY   = 2'd1,
    ST_FULL_BLOCKED = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    TRIG_NONE      = 2'd0,
    TRIG_THRESHOLD = 2'd1,
    TRIG_DELAY     = 2'd2
  } trig_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_QUEUE_CAP         = 3'd0,
    REG_EXPORT_BATCH_SIZE = 3'd1,
    REG_AGE_DELAY         = 3'd2,
    REG_BATCHING_ENABLED  = 3'd3,
    REG_OVERFLOW_BLOCK    = 3'd4
  } cfg_reg_t;

  typedef struct packed {
    logic [SIZE_W-1:0]  queue_cap;
    logic [SIZE_W-1:0]  export_batch_size;
    logic [DELAY_W-1:0] age_delay;
    logic               batching_enabled;
    logic               overflow_block;
  } cfg_t;

  // Input beat payload, last declared field in the lowest bits
  typedef struct packed {
    logic                    pad;
    logic signed [TIME_W-1:0] now_ms;
    logic [LIMIT_W-1:0]      take_limit;
    logic                    record_ready;
    logic signed [TIME_W-1:0] record_end_ms;
    logic [HANDLE_WIDTH-1:0] record_handle;
  } in_item_t;

  // Output beat payload, last declared field in the lowest bits
  typedef struct packed {
    logic [1:0]              pad;
    trig_t                   trigger;
    logic [HANDLE_WIDTH-1:0] item_handle;
    logic [TOTAL_W-1:0]      block_count;
    logic [TOTAL_W-1:0]      drop_count;
    logic [CNT_W-1:0]        queue_count;
    logic                    batch_due;
    logic                    evicted;
    logic                    refused;
    logic                    accepted;
    status_t                 status;
  } out_item_t;

  // Controller to datapath commands
  typedef struct packed {
    logic enq;
    logic chk;
    logic deq_start;
    logic pop;
  } ctl_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic out_free;
    logic n_zero;
    logic rem_one;
  } dp_stat_t;

endpackage

// ===== hw/rtl/beq_cfg.sv =====
// Configuration register file of the batch export queue.
module beq_cfg (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [beq_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [beq_pkg::CFG_DATA_W-1:0]     cfg_data,
  output beq_pkg::cfg_t                      cfg
);
  import beq_pkg::*;

  // Writes are always taken
  assign cfg_ready = 1'b1;

  // Update the addressed register, ignore unknown indexes
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.queue_cap         <= SIZE_W'(32);
      cfg.export_batch_size <= SIZE_W'(16);
      cfg.age_delay         <= DELAY_W'(5000);
      cfg.batching_enabled  <= 1'b1;
      cfg.overflow_block    <= 1'b0;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_QUEUE_CAP:         cfg.queue_cap         <= cfg_data[SIZE_W-1:0];
        REG_EXPORT_BATCH_SIZE: cfg.export_batch_size <= cfg_data[SIZE_W-1:0];
        REG_AGE_DELAY:         cfg.age_delay         <= cfg_data[DELAY_W-1:0];
        REG_BATCHING_ENABLED:  cfg.batching_enabled  <= cfg_data[0];
        REG_OVERFLOW_BLOCK:    cfg.overflow_block    <= cfg_data[0];
        default: ;
      endcase
    end
  end

endmodule

// ===== hw/rtl/beq_datapath.sv =====
// Queue storage, pointers, counters and output register of the batch export queue.
module beq_datapath (
  input  logic                 clk,
  input  logic                 rst,
  input  beq_pkg::cfg_t        cfg,
  input  beq_pkg::ctl_cmd_t    ctl,
  output beq_pkg::dp_stat_t    stat,
  input  beq_pkg::cmd_t        cmd,
  input  beq_pkg::in_item_t    item,
  output logic                 out_valid,
  input  logic                 out_ready,
  output beq_pkg::out_item_t   out_item,
  output logic                 out_last,
  output logic                 out_flag
);
  import beq_pkg::*;

  logic [HANDLE_WIDTH-1:0] handle_store   [STORE_DEPTH];
  logic [TIME_W-1:0]       end_time_store [STORE_DEPTH];

  logic [PTR_W-1:0]   head_ptr, tail_ptr;
  logic [CNT_W-1:0]   occupancy;
  logic [TOTAL_W-1:0] drop_total, blocked_total;
  logic [CNT_W-1:0]   rem;

  logic [CNT_W-1:0]        cap;
  logic                    full;
  logic [HANDLE_WIDTH-1:0] head_handle;
  logic [TIME_W-1:0]       head_end;
  logic                    do_block, do_drop, do_store;
  logic [CNT_W-1:0]        enq_occ;
  logic [TOTAL_W-1:0]      drop_next, blocked_next;
  logic [TIME_W-1:0]       age;
  logic                    age_hit;
  trig_t                   trig;
  logic [CNT_W-1:0]        lim, deq_n;
  logic                    load;
  out_item_t               res;
  logic                    res_last, res_flag;

  function automatic logic [PTR_W-1:0] next_ptr(input logic [PTR_W-1:0] p);
    return (p == PTR_W'(STORE_DEPTH - 1)) ? '0 : p + PTR_W'(1);
  endfunction

  // Effective capacity: zero acts as one, clamp to the store depth
  always_comb begin
    if (cfg.queue_cap == '0)
      cap = CNT_W'(1);
    else if (CNT_W'(cfg.queue_cap) > CNT_W'(STORE_DEPTH))
      cap = CNT_W'(STORE_DEPTH);
    else
      cap = CNT_W'(cfg.queue_cap);
  end

  assign full        = occupancy >= cap;
  assign head_handle = handle_store[head_ptr];
  assign head_end    = end_time_store[head_ptr];

  // Enqueue outcome and saturating totals
  assign do_block = item.record_ready && full && cfg.overflow_block;
  assign do_drop  = item.record_ready && full && !cfg.overflow_block;
  assign do_store = item.record_ready && !do_block;
  assign enq_occ  = do_drop ? occupancy : occupancy + CNT_W'(1);

  assign drop_next    = (do_drop && drop_total != '1) ? drop_total + TOTAL_W'(1)
                                                      : drop_total;
  assign blocked_next = (do_block && blocked_total != '1) ? blocked_total + TOTAL_W'(1)
                                                           : blocked_total;

  // Head age against schedule delay; a negative age never fires
  assign age     = item.now_ms - head_end;
  assign age_hit = !($signed(item.now_ms) < $signed(head_end)) &&
                   (age >= TIME_W'(cfg.age_delay));

  always_comb begin
    if (occupancy == '0)
      trig = TRIG_NONE;
    else if (!cfg.batching_enabled || occupancy >= CNT_W'(cfg.export_batch_size))
      trig = TRIG_THRESHOLD;
    else if (age_hit)
      trig = TRIG_DELAY;
    else
      trig = TRIG_NONE;
  end

  // Dequeue length; the result never exceeds the occupancy
  always_comb begin
    if (cmd == CMD_FLUSH)
      lim = occupancy;
    else if (item.take_limit == '0)
      lim = cfg.batching_enabled ? CNT_W'(cfg.export_batch_size) : occupancy;
    else
      lim = CNT_W'(item.take_limit);
    deq_n = (lim < occupancy) ? lim : occupancy;
  end

  assign stat.out_free = !out_valid || out_ready;
  assign stat.n_zero   = deq_n == '0;
  assign stat.rem_one  = rem == CNT_W'(1);

  assign load = ctl.enq || ctl.chk || (ctl.deq_start && stat.n_zero) || ctl.pop;

  // Build the next result beat
  always_comb begin
    res             = '0;
    res.status      = ST_OK;
    res.trigger     = TRIG_NONE;
    res.queue_count = occupancy;
    res.drop_count  = drop_total;
    res.block_count = blocked_total;
    res_last        = 1'b1;
    res_flag        = 1'b0;
    if (ctl.enq) begin
      res.drop_count  = drop_next;
      res.block_count = blocked_next;
      if (!item.record_ready) begin
        res.status = ST_NOT_READY;
      end else if (do_block) begin
        res.status  = ST_FULL_BLOCKED;
        res.refused = 1'b1;
      end else begin
        res.accepted    = 1'b1;
        res.evicted     = do_drop;
        res.queue_count = enq_occ;
        res.batch_due   = enq_occ >= CNT_W'(cfg.export_batch_size);
      end
    end else if (ctl.chk) begin
      res.trigger = trig;
    end else if (ctl.pop) begin
      res.item_handle = head_handle;
      res_flag        = 1'b1;
      res_last        = stat.rem_one;
    end
  end

  // Control state: pointers, occupancy, totals, pending pops, output valid
  always_ff @(posedge clk) begin
    if (rst) begin
      head_ptr      <= '0;
      tail_ptr      <= '0;
      occupancy     <= '0;
      drop_total    <= '0;
      blocked_total <= '0;
      rem           <= '0;
      out_valid     <= 1'b0;
    end else begin
      if (load)
        out_valid <= 1'b1;
      else if (out_ready)
        out_valid <= 1'b0;
      if (ctl.enq) begin
        drop_total    <= drop_next;
        blocked_total <= blocked_next;
        if (do_drop)
          head_ptr <= next_ptr(head_ptr);
        if (do_store) begin
          tail_ptr  <= next_ptr(tail_ptr);
          occupancy <= enq_occ;
        end
      end
      // Occupancy takes its final value at the start of a dequeue
      if (ctl.deq_start) begin
        occupancy <= occupancy - deq_n;
        rem       <= deq_n;
      end
      if (ctl.pop) begin
        head_ptr <= next_ptr(head_ptr);
        rem      <= rem - CNT_W'(1);
      end
    end
  end

  // Store writes and output payload
  always_ff @(posedge clk) begin
    if (ctl.enq && do_store) begin
      handle_store[tail_ptr]   <= item.record_handle;
      end_time_store[tail_ptr] <= item.record_end_ms;
    end
    if (load) begin
      out_item <= res;
      out_last <= res_last;
      out_flag <= res_flag;
    end
  end

endmodule

// ===== hw/rtl/beq_ctrl.sv =====
// Command sequencer of the batch export queue.
module beq_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  beq_pkg::cmd_t     cmd,
  input  beq_pkg::dp_stat_t stat,
  output beq_pkg::ctl_cmd_t ctl
);
  import beq_pkg::*;

  typedef enum logic {
    S_IDLE,
    S_POP
  } state_t;

  state_t state;
  logic   take;

  // Accept a beat only while idle with room in the output register
  always_comb begin
    in_ready      = (state == S_IDLE) && stat.out_free;
    take          = in_valid && in_ready;
    ctl.enq       = take && (cmd == CMD_ENQUEUE);
    ctl.chk       = take && (cmd == CMD_CHECK);
    ctl.deq_start = take && (cmd == CMD_DEQUEUE || cmd == CMD_FLUSH);
    ctl.pop       = (state == S_POP) && stat.out_free;
  end

  // Advance between idle and the record emission loop
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (ctl.deq_start && !stat.n_zero)
            state <= S_POP;
        end
        S_POP: begin
          if (ctl.pop && stat.rem_one)
            state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

// ===== hw/rtl/batch_export_queue.sv =====
// Top level of the batch export queue.
//
// Bounded FIFO of finished records (handle plus end time). Enqueue and check commands
// give one beat each; a dequeue or flush first sizes the batch and then removes the
// records one by one, each record one output beat, since the single read port at the
// head pointer yields one record a cycle while the output register has room. A removal
// of nothing gives one beat, marked last. The output register lets a new command enter
// while the last beat is still waiting, as long as it is taken in that same cycle.
// Record storage has no reset: it is only read where written. Configuration writes
// are accepted every cycle and must only be made while the queue is idle.
module batch_export_queue (
  input  logic                            clk,
  input  logic                            rst,
  // Configuration write channel
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [beq_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [beq_pkg::CFG_DATA_W-1:0]  cfg_data,
  // Command stream
  input  logic                            s_tvalid,
  output logic                            s_tready,
  // record_handle, record_end_ms, record_ready, take_limit, now_ms, zero pad
  input  beq_pkg::in_item_t               s_tdata,
  // cmd
  input  beq_pkg::cmd_t                   s_tuser,
  // Result stream
  output logic                            m_tvalid,
  input  logic                            m_tready,
  // status, accepted, refused, evicted, batch_due, queue_count,
  // drop_count, block_count, item_handle, trigger, zero pad
  output beq_pkg::out_item_t              m_tdata,
  // item_valid
  output logic                            m_tuser,
  output logic                            m_tlast
);
  import beq_pkg::*;

  cfg_t     cfg;
  ctl_cmd_t ctl;
  dp_stat_t stat;

  beq_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  beq_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_tvalid),
    .in_ready (s_tready),
    .cmd      (s_tuser),
    .stat     (stat),
    .ctl      (ctl)
  );

  beq_datapath u_dp (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .ctl       (ctl),
    .stat      (stat),
    .cmd       (s_tuser),
    .item      (s_tdata),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_item  (m_tdata),
    .out_last  (m_tlast),
    .out_flag  (m_tuser)
  );

endmodule
